// ===== src/tsp_pkg.sv =====
// ---------------------------------------------------------------------------
// TIFF stream parser package
// Shared types and constants for the grayscale TIFF stream parser.
// ---------------------------------------------------------------------------
package tsp_pkg;

  // Parser phases, one per region of the file.
  typedef enum logic [3:0] {
    PH_ORDER,
    PH_SKIP,
    PH_MAGIC,
    PH_OFFSET,
    PH_PIXELS,
    PH_COUNT,
    PH_ENTRY,
    PH_NEXT,
    PH_STOP
  } phase_t;

  // Result codes on the output word.
  localparam int KIND_W = 3;
  typedef enum logic [KIND_W-1:0] {
    KIND_GRAY   = 3'd0,
    KIND_WIDTH  = 3'd1,
    KIND_HEIGHT = 3'd2,
    KIND_ERROR  = 3'd3,
    KIND_DONE   = 3'd4
  } kind_t;

  localparam int DATA_W  = 8;
  localparam int VALUE_W = 16;

  // Header and directory constants.
  localparam logic [7:0]  BOM_LE      = 8'd73;
  localparam logic [15:0] TIFF_MAGIC  = 16'd42;
  localparam logic [15:0] TAG_WIDTH   = 16'd256;
  localparam logic [15:0] TAG_HEIGHT  = 16'd257;
  localparam logic [3:0]  ENTRY_LAST  = 4'd11;
  localparam logic [3:0]  VALUE_LO    = 4'd8;
  localparam logic [3:0]  VALUE_HI    = 4'd9;
  localparam logic [3:0]  NEXT_LAST   = 4'd3;

  // Q8 luma weights: 0.30, 0.59 and 0.11 times 256.
  localparam logic [7:0] COEF_R = 8'd77;
  localparam logic [7:0] COEF_G = 8'd151;
  localparam logic [7:0] COEF_B = 8'd28;

endpackage

// ===== src/tsp_in_if.sv =====
// ---------------------------------------------------------------------------
// TIFF stream parser input channel
// Valid/ready channel carrying one file byte per word.
// ---------------------------------------------------------------------------
interface tsp_in_if
  import tsp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== src/tsp_out_if.sv =====
// ---------------------------------------------------------------------------
// TIFF stream parser result channel
// Valid/ready channel carrying one result code and value per word.
// ---------------------------------------------------------------------------
interface tsp_out_if
  import tsp_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

// ===== src/tiff_stream_parser_grayscale.sv =====
// ---------------------------------------------------------------------------
// TIFF stream parser, grayscale
// Parses a TIFF header and first directory from a byte stream and converts
// the RGB bytes between header and directory into gray levels.
// ---------------------------------------------------------------------------
// Usage:
// The in_stream channel takes one file byte per word. The out_stream channel
// delivers at most one result per byte: a gray pixel for each complete RGB
// triple, the image width and height from tags 256 and 257, an error code for
// a bad magic number or a directory offset inside the header, and a done code
// after the next-directory offset. After error or done, bytes are consumed
// with no result until reset.
// Each byte is processed in the cycle it is accepted; a result it causes is
// valid on out_stream from the next cycle. One byte can be accepted every cycle,
// sustained, while results are drained.
// The result register is the only buffer: while a result waits with
// out_stream.ready low, in_stream.ready is low; it is high whenever that
// register is empty or being read in the same cycle.
// Reset (rst_n low, synchronous) returns the parser to the byte-order mark
// and empties the result register.
// ---------------------------------------------------------------------------
module tiff_stream_parser_grayscale
  import tsp_pkg::*;
#(
  parameter int OFFSET_BYTES = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  tsp_in_if.sink    in_stream,
  tsp_out_if.source out_stream
);

  localparam int          CNT_W    = 4;
  localparam logic [31:0] HDR_LEN  = 32'(4 + OFFSET_BYTES);
  localparam logic [CNT_W-1:0] OFFS_LAST = CNT_W'(OFFSET_BYTES - 1);

  // Byte assembly in either byte order.
  function automatic logic [31:0] gather_f(input logic [31:0] word,
                                           input logic [7:0]  b,
                                           input logic [1:0]  pos,
                                           input logic        be);
    logic [31:0] base;
    base = (pos == 2'd0) ? 32'd0 : word;
    if (be) begin
      return {base[23:0], b};
    end
    return base | (32'(b) << {pos, 3'b000});
  endfunction

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               big_endian_r, big_endian_nxt;
  logic [31:0]        word_r, word_nxt;
  logic [31:0]        pix_left_r, pix_left_nxt;
  logic [7:0]         red_r, red_nxt;
  logic [7:0]         green_r, green_nxt;
  logic [14:0]        entries_r, entries_nxt;
  logic [15:0]        tag_r, tag_nxt;
  logic               out_valid_r, out_valid_nxt;
  kind_t              out_kind_r, out_kind_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;

  logic               accept;
  logic               emit;
  logic [7:0]         b;
  logic [1:0]         gpos;
  logic [31:0]        gword;
  logic               offs_last;
  logic               offs_bad;
  logic [31:0]        pix_area;
  logic [31:0]        pix_dec;
  logic [15:0]        gray_sum;
  logic [14:0]        count_val;

  // Handshake: the result register is the skid stage.
  assign in_stream.ready = !out_valid_r || out_stream.ready;
  assign accept          = in_stream.valid && in_stream.ready;
  assign b               = in_stream.data_byte;

  // Gather position; directory value bytes restart at offset eight.
  assign gpos  = (phase_r == PH_ENTRY && cnt_r >= VALUE_LO) ? {1'b0, cnt_r[0]} : cnt_r[1:0];
  assign gword = gather_f(word_r, b, gpos, big_endian_r);

  // Offset field checks.
  assign offs_last = (cnt_r == OFFS_LAST);
  assign offs_bad  = (gword < HDR_LEN);
  assign pix_area  = gword - HDR_LEN;
  assign pix_dec   = pix_left_r - 32'd1;

  // Weighted sum of one triple; fits in 16 bits before the shift.
  assign gray_sum = 16'(red_r) * 16'(COEF_R) + 16'(green_r) * 16'(COEF_G)
                  + 16'(b) * 16'(COEF_B);

  // An entry count with the top bit set means no entries.
  assign count_val = gword[15] ? 15'd0 : gword[14:0];

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r)
        PH_ORDER: phase_nxt = PH_SKIP;
        PH_SKIP:  phase_nxt = PH_MAGIC;
        PH_MAGIC: begin
          if (cnt_r != '0) begin
            phase_nxt = (gword[15:0] != TIFF_MAGIC) ? PH_STOP : PH_OFFSET;
          end
        end
        PH_OFFSET: begin
          if (offs_last) begin
            if (offs_bad) begin
              phase_nxt = PH_STOP;
            end else begin
              phase_nxt = (pix_area == 32'd0) ? PH_COUNT : PH_PIXELS;
            end
          end
        end
        PH_PIXELS: begin
          if (pix_dec == 32'd0) begin
            phase_nxt = PH_COUNT;
          end
        end
        PH_COUNT: begin
          if (cnt_r != '0) begin
            phase_nxt = (count_val == 15'd0) ? PH_NEXT : PH_ENTRY;
          end
        end
        PH_ENTRY: begin
          if (cnt_r == ENTRY_LAST && entries_r == 15'd1) begin
            phase_nxt = PH_NEXT;
          end
        end
        PH_NEXT: begin
          if (cnt_r == NEXT_LAST) begin
            phase_nxt = PH_STOP;
          end
        end
        PH_STOP:  phase_nxt = PH_STOP;
        default:  phase_nxt = PH_STOP;
      endcase
    end
  end

  // Field counters, assembled words and results.
  always_comb begin
    cnt_nxt        = cnt_r;
    big_endian_nxt = big_endian_r;
    word_nxt       = word_r;
    pix_left_nxt   = pix_left_r;
    red_nxt        = red_r;
    green_nxt      = green_r;
    entries_nxt    = entries_r;
    tag_nxt        = tag_r;
    emit           = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_value_nxt  = out_value_r;
    if (accept) begin
      unique case (phase_r)
        PH_ORDER: big_endian_nxt = (b != BOM_LE);
        PH_SKIP:  cnt_nxt = '0;
        PH_MAGIC: begin
          word_nxt = gword;
          if (cnt_r == '0) begin
            cnt_nxt = CNT_W'(1);
          end else begin
            cnt_nxt = '0;
            if (gword[15:0] != TIFF_MAGIC) begin
              emit          = 1'b1;
              out_kind_nxt  = KIND_ERROR;
              out_value_nxt = '0;
            end
          end
        end
        PH_OFFSET: begin
          word_nxt = gword;
          cnt_nxt  = cnt_r + CNT_W'(1);
          if (offs_last) begin
            cnt_nxt = '0;
            if (offs_bad) begin
              emit          = 1'b1;
              out_kind_nxt  = KIND_ERROR;
              out_value_nxt = '0;
            end else begin
              pix_left_nxt = pix_area;
            end
          end
        end
        PH_PIXELS: begin
          pix_left_nxt = pix_dec;
          if (cnt_r == CNT_W'(0)) begin
            red_nxt = b;
            cnt_nxt = CNT_W'(1);
          end else if (cnt_r == CNT_W'(1)) begin
            green_nxt = b;
            cnt_nxt   = CNT_W'(2);
          end else begin
            cnt_nxt       = '0;
            emit          = 1'b1;
            out_kind_nxt  = KIND_GRAY;
            out_value_nxt = {8'd0, gray_sum[15:8]};
          end
          // A partial triple at the end of the pixel area is dropped.
          if (pix_dec == 32'd0) begin
            cnt_nxt = '0;
          end
        end
        PH_COUNT: begin
          word_nxt = gword;
          if (cnt_r == '0) begin
            cnt_nxt = CNT_W'(1);
          end else begin
            cnt_nxt     = '0;
            entries_nxt = count_val;
          end
        end
        PH_ENTRY: begin
          if (cnt_r < CNT_W'(2) || cnt_r == VALUE_LO || cnt_r == VALUE_HI) begin
            word_nxt = gword;
          end
          if (cnt_r == CNT_W'(1)) begin
            tag_nxt = gword[15:0];
          end
          if (cnt_r == VALUE_HI) begin
            if (tag_r == TAG_WIDTH) begin
              emit          = 1'b1;
              out_kind_nxt  = KIND_WIDTH;
              out_value_nxt = gword[15:0];
            end else if (tag_r == TAG_HEIGHT) begin
              emit          = 1'b1;
              out_kind_nxt  = KIND_HEIGHT;
              out_value_nxt = gword[15:0];
            end
          end
          cnt_nxt = cnt_r + CNT_W'(1);
          if (cnt_r == ENTRY_LAST) begin
            cnt_nxt     = '0;
            entries_nxt = entries_r - 15'd1;
          end
        end
        PH_NEXT: begin
          word_nxt = gword;
          cnt_nxt  = cnt_r + CNT_W'(1);
          if (cnt_r == NEXT_LAST) begin
            cnt_nxt       = '0;
            emit          = 1'b1;
            out_kind_nxt  = KIND_DONE;
            out_value_nxt = '0;
          end
        end
        PH_STOP: cnt_nxt = cnt_r;
        default: cnt_nxt = cnt_r;
      endcase
    end
  end

  // Result register valid flag.
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stream.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_ORDER;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers; every one is written before it is read.
  always_ff @(posedge clk) begin
    big_endian_r <= big_endian_nxt;
    word_r       <= word_nxt;
    pix_left_r   <= pix_left_nxt;
    red_r        <= red_nxt;
    green_r      <= green_nxt;
    entries_r    <= entries_nxt;
    tag_r        <= tag_nxt;
    out_kind_r   <= out_kind_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign out_stream.valid = out_valid_r;
  assign out_stream.kind  = out_kind_r;
  assign out_stream.value = out_value_r;

endmodule

// ===== src/tsp_checker.sv =====
// ---------------------------------------------------------------------------
// TIFF stream parser checker
// Port-level assertions for the grayscale TIFF stream parser.
// ---------------------------------------------------------------------------
module tsp_checker
  import tsp_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [KIND_W-1:0]  out_kind,
  input logic [VALUE_W-1:0] out_value
);

  // A stalled result word stays until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_value))
    else $error("result word changed while stalled");

  // Input is held off only while a result word is stalled.
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  // Gray levels are 8 bits after the Q8 shift.
  a_gray_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_GRAY |-> out_value[15:8] == 8'd0)
    else $error("gray level above 255");

  // Error and done words carry a zero value.
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_ERROR || out_kind == KIND_DONE) |-> out_value == '0)
    else $error("nonzero value on error or done word");

  // No result is valid right after a delivered error or done word.
  a_terminal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_kind == KIND_ERROR || out_kind == KIND_DONE)
    |=> !out_valid)
    else $error("result after error or done");

endmodule

bind tiff_stream_parser_grayscale tsp_checker u_tsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_stream.ready),
  .out_valid (out_stream.valid),
  .out_ready (out_stream.ready),
  .out_kind  (out_stream.kind),
  .out_value (out_stream.value)
);

// ===== sim/tiff_stream_parser_grayscale_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// TIFF stream parser, grayscale: testbench
// Feeds one TIFF byte stream through the parser with random gaps on both
// channels and checks every result word against a byte-level predictor or a
// hand-typed value. The file shape (byte order, bad magic, short offset, empty
// or filled pixel area, directory size) is drawn per run, since only one reset is allowed.
// ---------------------------------------------------------------------------
module tiff_stream_parser_grayscale_tb;
  import tsp_pkg::*;

  localparam int OFS_BYTES      = 4;
  localparam int HDR_BYTES      = 4 + OFS_BYTES;
  localparam int ENTRY_BYTES    = 12;
  localparam int NEXT_BYTES     = 4;
  localparam int IDLE_PCT       = 32;
  localparam int ITEMS_TARGET   = 1500;
  localparam int SEND_CALM_LO   = 600;
  localparam int SEND_CALM_HI   = 900;
  localparam int HOLD_FROM      = 2;
  localparam int HOLD_LEN       = 200;
  localparam int TAKE_CALM_LO   = 1000;
  localparam int TAKE_CALM_HI   = 1500;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_LIMIT    = 4000;
  localparam int TAIL_CYCLES    = 8;

  // Shapes of the single file sent in one run.
  typedef enum int {
    FILE_BAD_MAGIC,
    FILE_SHORT_OFFSET,
    FILE_NO_PIXELS,
    FILE_PIXELS
  } file_shape_t;

  typedef struct packed {
    kind_t             kind;
    logic [VALUE_W-1:0] value;
  } result_word_t;

  typedef struct packed {
    bit                 hit;
    kind_t              kind;
    logic [VALUE_W-1:0] value;
  } parse_out_t;

  typedef struct {
    logic [7:0]         data;
    bit                 typed;
    kind_t              kind;
    logic [VALUE_W-1:0] value;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  tsp_in_if  in_bus ();
  tsp_out_if out_bus ();

  tiff_stream_parser_grayscale #(
    .OFFSET_BYTES(OFS_BYTES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_bus),
    .out_stream(out_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  stim_row_t    stim_rows[$];
  result_word_t due_results[$];
  bit           file_big;
  int           mismatch_count = 0;
  int           quiet_cycles = 0;

  // Parser state as the predictor sees it.
  phase_t      pr_phase    = PH_ORDER;
  logic [31:0] pr_count    = '0;
  bit          pr_big      = 1'b0;
  logic [31:0] pr_word     = '0;
  logic [31:0] pr_pix_left = '0;
  logic [7:0]  pr_red      = '0;
  logic [7:0]  pr_green    = '0;
  logic [15:0] pr_entries  = '0;
  logic [15:0] pr_tag      = '0;

  // Multi-byte fields are built up in the byte order chosen by the mark.
  function automatic void gather_byte(logic [7:0] b, logic [31:0] pos);
    if (pos == 0) pr_word = '0;
    if (pr_big) begin
      pr_word = {pr_word[23:0], b};
    end else begin
      pr_word = pr_word | (32'(b) << (8 * pos[1:0]));
    end
  endfunction

  // Advances the predicted parser by one byte and returns its result, if any.
  function automatic parse_out_t parse_byte(logic [7:0] b);
    parse_out_t  r;
    logic [31:0] pos;
    logic [31:0] luma;
    r = '{1'b0, KIND_GRAY, 16'd0};
    case (pr_phase)
      PH_ORDER: begin
        pr_big   = (b != BOM_LE);
        pr_phase = PH_SKIP;
      end
      PH_SKIP: begin
        pr_phase = PH_MAGIC;
        pr_count = 0;
      end
      PH_MAGIC: begin
        gather_byte(b, pr_count);
        if (pr_count == 0) begin
          pr_count = 1;
        end else if (pr_word[15:0] != TIFF_MAGIC) begin
          pr_phase = PH_STOP;
          r = '{1'b1, KIND_ERROR, 16'd0};
        end else begin
          pr_phase = PH_OFFSET;
          pr_count = 0;
        end
      end
      PH_OFFSET: begin
        gather_byte(b, pr_count);
        pr_count++;
        if (pr_count == OFS_BYTES) begin
          if (pr_word < HDR_BYTES) begin
            pr_phase = PH_STOP;
            r = '{1'b1, KIND_ERROR, 16'd0};
          end else begin
            pr_pix_left = pr_word - HDR_BYTES;
            pr_count    = 0;
            pr_phase    = (pr_pix_left == 0) ? PH_COUNT : PH_PIXELS;
          end
        end
      end
      PH_PIXELS: begin
        if (pr_count == 0) begin
          pr_red   = b;
          pr_count = 1;
        end else if (pr_count == 1) begin
          pr_green = b;
          pr_count = 2;
        end else begin
          luma = 32'(COEF_R) * pr_red + 32'(COEF_G) * pr_green + 32'(COEF_B) * b;
          r = '{1'b1, KIND_GRAY, 16'(luma >> 8)};
          pr_count = 0;
        end
        pr_pix_left--;
        if (pr_pix_left == 0) begin
          pr_phase = PH_COUNT;
          pr_count = 0;
        end
      end
      PH_COUNT: begin
        gather_byte(b, pr_count);
        if (pr_count == 0) begin
          pr_count = 1;
        end else begin
          pr_entries = pr_word[15:0];
          if (pr_entries >= 16'h8000) pr_entries = '0;
          pr_count = 0;
          pr_phase = (pr_entries == 0) ? PH_NEXT : PH_ENTRY;
        end
      end
      PH_ENTRY: begin
        pos = pr_count;
        if (pos < 2) begin
          gather_byte(b, pos);
          if (pos == 1) pr_tag = pr_word[15:0];
        end else if (pos == VALUE_LO || pos == VALUE_HI) begin
          gather_byte(b, pos - VALUE_LO);
          if (pos == VALUE_HI) begin
            if (pr_tag == TAG_WIDTH) begin
              r = '{1'b1, KIND_WIDTH, pr_word[15:0]};
            end else if (pr_tag == TAG_HEIGHT) begin
              r = '{1'b1, KIND_HEIGHT, pr_word[15:0]};
            end
          end
        end
        pr_count++;
        if (pr_count >= ENTRY_BYTES) begin
          pr_count = 0;
          pr_entries--;
          if (pr_entries == 0) pr_phase = PH_NEXT;
        end
      end
      PH_NEXT: begin
        gather_byte(b, pr_count);
        pr_count++;
        if (pr_count == NEXT_BYTES) begin
          pr_count = 0;
          pr_phase = PH_STOP;
          r = '{1'b1, KIND_DONE, 16'd0};
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Stimulus table helpers.
  function automatic void add_byte(logic [7:0] d);
    stim_row_t row;
    row = '{d, 1'b0, KIND_GRAY, 16'd0};
    stim_rows.push_back(row);
  endfunction

  // The last byte added carries an expectation typed in by hand.
  function automatic void mark_last(kind_t k, logic [VALUE_W-1:0] v);
    stim_row_t row;
    row = stim_rows.pop_back();
    row.typed = 1'b1;
    row.kind  = k;
    row.value = v;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_field(logic [31:0] v, int nbytes);
    int idx;
    for (int i = 0; i < nbytes; i++) begin
      idx = file_big ? (nbytes - 1 - i) : i;
      add_byte(v[8*idx +: 8]);
    end
  endfunction

  function automatic void add_triple(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic [VALUE_W-1:0] gray);
    add_byte(r);
    add_byte(g);
    add_byte(b);
    mark_last(KIND_GRAY, gray);
  endfunction

  // Main sequence: build the file, reset, send every byte, then drain.
  initial begin
    file_shape_t shape;
    logic [7:0]  order_mark;
    logic [15:0] magic;
    logic [31:0] offset;
    logic [15:0] n_entries;
    logic [15:0] tag;
    logic [15:0] tag_value;
    int          n_pix;
    int          pick;
    int          waited;
    stim_row_t   row;
    parse_out_t  res;

    in_bus.valid     = 1'b0;
    in_bus.data_byte = '0;
    rst_n            = 1'b0;

    pick = $urandom_range(0, 9);
    shape = (pick == 0) ? FILE_BAD_MAGIC :
            (pick == 1) ? FILE_SHORT_OFFSET :
            (pick == 2) ? FILE_NO_PIXELS : FILE_PIXELS;

    // Header: byte-order mark, ignored byte, magic, directory offset.
    file_big = 1'($urandom_range(0, 1));
    if (file_big) begin
      order_mark = 8'($urandom_range(0, 254));
      if (order_mark >= BOM_LE) order_mark++;
    end else begin
      order_mark = BOM_LE;
    end
    add_byte(order_mark);
    add_byte(8'($urandom_range(0, 255)));

    if (shape == FILE_BAD_MAGIC) begin
      magic = $urandom_range(0, 1) ? 16'h2A00 : 16'($urandom_range(0, 65535));
      if (magic == TIFF_MAGIC) magic = 16'h2A00;
      add_field(32'(magic), 2);
      mark_last(KIND_ERROR, 16'd0);
    end else begin
      add_field(32'(TIFF_MAGIC), 2);
    end

    n_pix = 0;
    if (shape == FILE_SHORT_OFFSET) begin
      offset = $urandom_range(0, HDR_BYTES - 1);
      add_field(offset, OFS_BYTES);
      mark_last(KIND_ERROR, 16'd0);
    end else if (shape == FILE_NO_PIXELS) begin
      add_field(32'(HDR_BYTES), OFS_BYTES);
    end else if (shape == FILE_PIXELS) begin
      n_pix = 15 + $urandom_range(1000, 1200);
      add_field(32'(HDR_BYTES + n_pix), OFS_BYTES);
      // Color extremes: black, white and each primary at full scale.
      add_triple(8'd0, 8'd0, 8'd0, 16'd0);
      add_triple(8'd255, 8'd255, 8'd255, 16'd255);
      add_triple(8'd255, 8'd0, 8'd0, 16'd76);
      add_triple(8'd0, 8'd255, 8'd0, 16'd150);
      add_triple(8'd0, 8'd0, 8'd255, 16'd27);
      // The rest of the pixel area; its length may end in a partial triple.
      for (int i = 15; i < n_pix; i++) add_byte(8'($urandom_range(0, 255)));
    end

    if (shape == FILE_NO_PIXELS || shape == FILE_PIXELS) begin
      // Directory: entry count, entries, next-directory offset.
      pick = $urandom_range(0, 7);
      if (shape == FILE_NO_PIXELS) n_entries = 16'($urandom_range(60, 110));
      else if (pick == 0)          n_entries = 16'd0;
      else if (pick == 1)          n_entries = 16'($urandom_range(16'h8000, 16'hFFFF));
      else                         n_entries = 16'($urandom_range(1, 30));
      add_field(32'(n_entries), 2);
      for (int e = 0; e < (n_entries[15] ? 0 : int'(n_entries)); e++) begin
        pick = $urandom_range(0, 4);
        tag = (pick < 2) ? TAG_WIDTH : (pick < 4) ? TAG_HEIGHT :
              16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 3);
        tag_value = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF :
                    16'($urandom_range(0, 65535));
        add_field(32'(tag), 2);
        add_field($urandom_range(0, 65535), 2);
        add_field($urandom, 4);
        add_field(32'(tag_value), 2);
        add_field($urandom_range(0, 65535), 2);
      end
      add_field($urandom, NEXT_BYTES);
    end

    // Bytes after the end of parsing must be swallowed silently; they also
    // bring a short file up to the run's item count.
    pick = $urandom_range(20, 80);
    if (stim_rows.size() + pick < ITEMS_TARGET) pick = ITEMS_TARGET - stim_rows.size();
    for (int i = 0; i < pick; i++) add_byte(8'($urandom_range(0, 255)));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk the table; each word is predicted at the edge that accepts it.
    for (int i = 0; i < stim_rows.size(); i++) begin
      row = stim_rows[i];
      while (!(i >= SEND_CALM_LO && i < SEND_CALM_HI) &&
             $urandom_range(0, 99) < IDLE_PCT) begin
        in_bus.valid = 1'b0;
        @(negedge clk);
      end
      in_bus.valid     = 1'b1;
      in_bus.data_byte = row.data;
      do @(posedge clk); while (!in_bus.ready);
      res = parse_byte(row.data);
      if (row.typed) begin
        due_results.push_back('{row.kind, row.value});
      end else if (res.hit) begin
        due_results.push_back('{res.kind, res.value});
      end
      @(negedge clk);
    end
    in_bus.valid = 1'b0;

    waited = 0;
    while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (due_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, due_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, and a stretch with none.
  // The hold-off starts right after reset so that the first result of any
  // file shape waits in the block and stalls its input.
  initial begin
    int cyc;
    cyc = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n) cyc++;
      if (cyc >= HOLD_FROM && cyc < HOLD_FROM + HOLD_LEN) begin
        out_bus.ready = 1'b0;
      end else if (cyc >= TAKE_CALM_LO && cyc < TAKE_CALM_HI) begin
        out_bus.ready = 1'b1;
      end else begin
        out_bus.ready = ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Compare each result word with the oldest expectation; watch for hangs.
  always @(posedge clk) begin
    result_word_t exp_word;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d value %0d",
                 $time, out_bus.kind, out_bus.value);
        mismatch_count++;
      end else begin
        exp_word = due_results.pop_front();
        if (out_bus.kind !== exp_word.kind) begin
          $display("%0t: kind mismatch, expected %0d, actual %0d",
                   $time, exp_word.kind, out_bus.kind);
          mismatch_count++;
        end
        if (out_bus.value !== exp_word.value) begin
          $display("%0t: value mismatch, expected %0d, actual %0d",
                   $time, exp_word.value, out_bus.value);
          mismatch_count++;
        end
      end
    end

    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no word accepted for %0d cycles", $time, quiet_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
